// ===== src/tga_rle_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tga_rle_pkg
// Shared types and constants for the TGA pixel-data decoder.
// ----------------------------------------------------------------------------
package tga_rle_pkg;

  // Longest packet accepted from a run-length header.
  localparam logic [7:0] MAX_RUN = 8'd128;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_RLE_MODE        = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_BYTES_PER_PIXEL = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_COLUMNS   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_ROWS      = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_BOTTOM_UP       = 3'd4;

  localparam logic [2:0]  BPP_24       = 3'd3;
  localparam logic [15:0] MIN_COLUMNS  = 16'd4;
  localparam logic [7:0]  OPAQUE_ALPHA = 8'd255;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       first_byte;
    logic       final_byte;
  } in_item_t;

  typedef struct packed {
    logic [15:0] out_row;
    logic [15:0] out_column;
    logic [7:0]  repeat_count;
    logic [7:0]  colour_byte0;
    logic [7:0]  colour_byte1;
    logic [7:0]  colour_byte2;
    logic [7:0]  alpha;
    logic        segment_last;
    logic        image_done;
    logic        truncated;
  } out_item_t;

  // controller -> datapath
  typedef struct packed {
    logic take_byte;
    logic emit_seg;
  } dp_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic out_free;
    logic want_span;
    logic seg_last;
  } dp_status_t;

endpackage

// ===== src/tga_rle_ctrl.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tga_rle_ctrl
// Sequencer: takes one byte at a time, then walks the segments of a pixel.
// ----------------------------------------------------------------------------
module tga_rle_ctrl (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_valid,
  output logic                   in_stall,
  input  tga_rle_pkg::dp_status_t status,
  output tga_rle_pkg::dp_cmd_t    cmd
);
  import tga_rle_pkg::*;

  typedef enum logic {
    ST_IDLE,
    ST_SPAN
  } state_t;

  state_t state_r, state_nxt;

  always_comb begin
    cmd.take_byte = (state_r == ST_IDLE) && in_valid && status.out_free;
    cmd.emit_seg  = (state_r == ST_SPAN) && status.out_free;
    in_stall      = !((state_r == ST_IDLE) && status.out_free);
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (cmd.take_byte && status.want_span) state_nxt = ST_SPAN;
      end
      ST_SPAN: begin
        if (cmd.emit_seg && status.seg_last) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

// ===== src/tga_rle_dp.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tga_rle_dp
// Config registers, decode state, segment splitter and output register.
// ----------------------------------------------------------------------------
module tga_rle_dp (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  tga_rle_pkg::in_item_t                 in_data,
  output logic                                  out_valid,
  input  logic                                  out_stall,
  output tga_rle_pkg::out_item_t                out_data,
  input  logic                                  cfg_we,
  input  logic [tga_rle_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [tga_rle_pkg::CFG_DATA_W-1:0]    cfg_data,
  input  tga_rle_pkg::dp_cmd_t                  cmd,
  output tga_rle_pkg::dp_status_t               status
);
  import tga_rle_pkg::*;

  // configuration
  logic        rle_mode_r;
  logic [2:0]  bpp_r;
  logic [15:0] cols_r;
  logic [15:0] rows_r;
  logic        bottom_up_r;

  // decode state
  logic [15:0] row_r, row_nxt;
  logic [15:0] col_r, col_nxt;
  logic [7:0]  prem_r, prem_nxt;
  logic        is_run_r, is_run_nxt;
  logic [1:0]  bip_r, bip_nxt;
  logic [23:0] pix_r, pix_nxt;
  logic        fin_r, fin_nxt;
  logic [7:0]  alpha_r, alpha_nxt;
  logic [7:0]  span_rem_r, span_rem_nxt;
  logic        final_r, final_nxt;

  // output register
  logic        out_valid_r, out_valid_nxt;
  out_item_t   out_data_r, out_data_nxt;

  // restart-adjusted view of the state for the byte being taken
  logic [15:0] eff_row, eff_col;
  logic [7:0]  eff_prem;
  logic        eff_run, eff_fin;
  logic [1:0]  eff_bip;
  logic [23:0] eff_pix;

  logic        narrow, is_hdr, pix_more, pix_done, marker_cond;
  logic [7:0]  hdr_count, px_count;
  logic [23:0] pix_upd;
  logic [7:0]  b;

  // segment splitter
  logic [15:0] avail, drow;
  logic [7:0]  seg_n;
  logic [16:0] col_sum;
  logic        row_end, seg_done, seg_last, seg_trunc;
  logic [7:0]  rem_after;
  logic        load_seg, load_marker;

  // status toward the sequencer
  logic        out_free, want_span;

  // ---------------- configuration ----------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rle_mode_r  <= 1'b0;
      bpp_r       <= 3'd4;
      cols_r      <= 16'd4;
      rows_r      <= 16'd1;
      bottom_up_r <= 1'b1;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_RLE_MODE:        rle_mode_r  <= cfg_data[0];
        CFG_BYTES_PER_PIXEL: bpp_r       <= cfg_data[2:0];
        CFG_IMAGE_COLUMNS:   cols_r      <= cfg_data;
        CFG_IMAGE_ROWS:      rows_r      <= cfg_data;
        CFG_BOTTOM_UP:       bottom_up_r <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // ---------------- byte decode ----------------
  always_comb begin
    b = in_data.data_byte;
    if (in_data.first_byte) begin
      eff_row  = rows_r - 16'd1;
      eff_col  = '0;
      eff_prem = '0;
      eff_run  = 1'b0;
      eff_bip  = '0;
      eff_pix  = '0;
      eff_fin  = (rows_r == 16'd0);
    end else begin
      eff_row  = row_r;
      eff_col  = col_r;
      eff_prem = prem_r;
      eff_run  = is_run_r;
      eff_bip  = bip_r;
      eff_pix  = pix_r;
      eff_fin  = fin_r;
    end

    narrow    = cols_r < MIN_COLUMNS;
    is_hdr    = rle_mode_r && (eff_prem == 8'd0);
    hdr_count = {1'b0, b[6:0]} + 8'd1;
    if (hdr_count > MAX_RUN) hdr_count = MAX_RUN;

    pix_upd = eff_pix;
    case (eff_bip)
      2'd0:    pix_upd[7:0]   = b;
      2'd1:    pix_upd[15:8]  = b;
      2'd2:    pix_upd[23:16] = b;
      default: ;
    endcase

    // more bytes still needed for this pixel
    pix_more = (bpp_r == BPP_24) ? (eff_bip < 2'd2) : (eff_bip < 2'd3);
    pix_done = !is_hdr && !pix_more;
    px_count = (rle_mode_r && eff_run) ? eff_prem : 8'd1;

    marker_cond = !eff_fin && (narrow || (in_data.final_byte && !pix_done));
    want_span   = !eff_fin && !narrow && pix_done;
  end

  // ---------------- segment splitter ----------------
  always_comb begin
    avail     = (col_r < cols_r) ? (cols_r - col_r) : 16'd1;
    seg_n     = ({8'd0, span_rem_r} < avail) ? span_rem_r : avail[7:0];
    drow      = bottom_up_r ? row_r : (rows_r - 16'd1 - row_r);
    col_sum   = {1'b0, col_r} + {9'd0, seg_n};
    row_end   = col_sum >= {1'b0, cols_r};
    seg_done  = row_end && (row_r == 16'd0);
    rem_after = span_rem_r - seg_n;
    seg_last  = (rem_after == 8'd0) || seg_done;
    seg_trunc = seg_last && final_r && !seg_done;
  end

  assign load_seg    = cmd.emit_seg;
  assign load_marker = cmd.take_byte && marker_cond;

  // ---------------- next state ----------------
  always_comb begin
    row_nxt       = row_r;
    col_nxt       = col_r;
    prem_nxt      = prem_r;
    is_run_nxt    = is_run_r;
    bip_nxt       = bip_r;
    pix_nxt       = pix_r;
    fin_nxt       = fin_r;
    alpha_nxt     = alpha_r;
    span_rem_nxt  = span_rem_r;
    final_nxt     = final_r;

    if (cmd.take_byte) begin
      row_nxt    = eff_row;
      col_nxt    = eff_col;
      prem_nxt   = eff_prem;
      is_run_nxt = eff_run;
      bip_nxt    = eff_bip;
      pix_nxt    = eff_pix;
      fin_nxt    = eff_fin;
      if (!eff_fin) begin
        if (narrow) begin
          fin_nxt = 1'b1;
        end else if (is_hdr) begin
          prem_nxt   = hdr_count;
          is_run_nxt = b[7];
          bip_nxt    = '0;
        end else begin
          pix_nxt = pix_upd;
          if (pix_more) begin
            bip_nxt = eff_bip + 2'd1;
          end else begin
            bip_nxt      = '0;
            alpha_nxt    = (bpp_r == BPP_24) ? OPAQUE_ALPHA : b;
            span_rem_nxt = px_count;
            final_nxt    = in_data.final_byte;
            if (rle_mode_r) prem_nxt = eff_prem - px_count;
          end
        end
      end
    end

    if (cmd.emit_seg) begin
      span_rem_nxt = rem_after;
      if (row_end) begin
        col_nxt = '0;
        if (row_r == 16'd0) fin_nxt = 1'b1;
        else                row_nxt = row_r - 16'd1;
      end else begin
        col_nxt = col_sum[15:0];
      end
    end
  end

  // ---------------- output register ----------------
  always_comb begin
    out_data_nxt  = out_data_r;
    out_valid_nxt = out_valid_r && out_stall;
    if (load_seg) begin
      out_valid_nxt             = 1'b1;
      out_data_nxt.out_row      = drow;
      out_data_nxt.out_column   = col_r;
      out_data_nxt.repeat_count = seg_n;
      out_data_nxt.colour_byte0 = pix_r[7:0];
      out_data_nxt.colour_byte1 = pix_r[15:8];
      out_data_nxt.colour_byte2 = pix_r[23:16];
      out_data_nxt.alpha        = alpha_r;
      out_data_nxt.segment_last = seg_last;
      out_data_nxt.image_done   = seg_done;
      out_data_nxt.truncated    = seg_trunc;
    end else if (load_marker) begin
      out_valid_nxt             = 1'b1;
      out_data_nxt              = '0;
      out_data_nxt.segment_last = 1'b1;
      out_data_nxt.truncated    = 1'b1;
    end
    out_free = !out_valid_r || !out_stall;
  end

  assign status = '{out_free: out_free, want_span: want_span, seg_last: seg_last};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_r       <= '0;
      col_r       <= '0;
      prem_r      <= '0;
      is_run_r    <= 1'b0;
      bip_r       <= '0;
      pix_r       <= '0;
      fin_r       <= 1'b0;
      span_rem_r  <= '0;
      final_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      row_r       <= row_nxt;
      col_r       <= col_nxt;
      prem_r      <= prem_nxt;
      is_run_r    <= is_run_nxt;
      bip_r       <= bip_nxt;
      pix_r       <= pix_nxt;
      fin_r       <= fin_nxt;
      span_rem_r  <= span_rem_nxt;
      final_r     <= final_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    alpha_r    <= alpha_nxt;
    out_data_r <= out_data_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

`ifndef SYNTHESIS
  // a held transaction is never overwritten
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_stall) |-> !(load_seg || load_marker))
    else $error("output register overwritten while stalled");

  // a segment is only cut while pixels remain
  a_span_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.emit_seg |-> (span_rem_r != 8'd0))
    else $error("segment emitted with no pixels left");

  // byte intake and segment output never overlap
  a_cmd_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
    !(cmd.take_byte && cmd.emit_seg))
    else $error("byte taken during segment output");
`endif

endmodule

// ===== src/tga_rle_pixel_decoder.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tga_rle_pixel_decoder
// TGA pixel-data decoder (raw and run-length, 24/32 bpp) emitting row-bounded
// write segments.
// ----------------------------------------------------------------------------
//  channel | ports                          | transaction
//  --------+--------------------------------+-------------------------------
//  in      | in_valid, in_stall, in_data    | one pixel-data byte
//  out     | out_valid, out_stall, out_data | one write segment or marker
//  cfg     | cfg_we, cfg_index, cfg_data    | one register write
//
//  A byte that finishes a pixel is followed by its segments: one for raw
//  data, up to 33 for a 128-pixel run split over 4-column rows; no byte is
//  taken until the last is cut. The segment splitter cuts one segment per
//  cycle while the output is not stalled. Synchronous active-low reset loads
//  the register defaults and an idle decoder. A stalled output holds the
//  result register and blocks both byte intake and segment cutting.
// ----------------------------------------------------------------------------
module tga_rle_pixel_decoder (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  in_valid,
  output logic                                  in_stall,
  input  tga_rle_pkg::in_item_t                 in_data,
  output logic                                  out_valid,
  input  logic                                  out_stall,
  output tga_rle_pkg::out_item_t                out_data,
  input  logic                                  cfg_we,
  input  logic [tga_rle_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [tga_rle_pkg::CFG_DATA_W-1:0]    cfg_data
);
  import tga_rle_pkg::*;

  dp_cmd_t    cmd;
  dp_status_t status;

  // sequencer: decides when a byte is taken and when a segment is cut
  tga_rle_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .status   (status),
    .cmd      (cmd)
  );

  // decode state, row/column walk and result register
  tga_rle_dp u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cmd       (cmd),
    .status    (status)
  );

endmodule
